[rtl/bpss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery pack switch sequencer package
// Transaction types, phase encoding and the command, state and status codes
// shared by the sequencer core and its top level.
// ----------------------------------------------------------------------------
package bpss_pkg;

    // Request and event codes carried in the func field.
    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_SWITCH  = 3'd1;
    localparam logic [2:0] FUNC_MERGE   = 3'd2;
    localparam logic [2:0] FUNC_RELEASE = 3'd3;
    localparam logic [2:0] FUNC_DONE    = 3'd4;

    // Pack command codes.
    localparam logic [3:0] CMD_CHARGE    = 4'd1;
    localparam logic [3:0] CMD_ONLY_DIS  = 4'd2;
    localparam logic [3:0] CMD_DISCHARGE = 4'd3;
    localparam logic [3:0] CMD_STANDBY   = 4'd4;
    localparam logic [3:0] CMD_NONE      = 4'd10;

    localparam logic [3:0] PACK_NONE = 4'd15;

    // Pack state codes.
    localparam logic [2:0] ST_ABSENT   = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_STANDBY  = 3'd2;
    localparam logic [2:0] ST_DIS      = 3'd3;
    localparam logic [2:0] ST_CHG      = 3'd4;
    localparam logic [2:0] ST_ONLY_DIS = 3'd5;

    // Request status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_REJECTED = 2'd1;
    localparam logic [1:0] STAT_BUSY     = 2'd2;
    localparam logic [1:0] STAT_ALREADY  = 2'd3;

    // Packs described by the pack_states and connected_mask fields.
    localparam int FIELD_PACKS = 3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PRE   = 3'd1,
        PH_MAIN  = 3'd2,
        PH_FIN   = 3'd3,
        PH_MERGE = 3'd4,
        PH_RECOV = 3'd5,
        PH_FAIL  = 3'd6
    } phase_t;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] port;
        logic [3:0] cmd;
        logic       cmd_failed;
        logic [8:0] pack_states;
        logic [2:0] connected_mask;
    } in_t;

    typedef struct packed {
        logic       issue_valid;
        logic [2:0] issue_pack;
        logic [3:0] issue_cmd;
        logic       report_valid;
        logic       report_ok;
        logic [2:0] report_pack;
        logic [1:0] request_status;
        logic [2:0] phase_now;
    } out_t;

    // Sequencer control state, apart from the shadow pack states.
    typedef struct packed {
        phase_t      phase;
        logic [15:0] elapsed;
        logic [3:0]  pending;
        logic        in_flight;
        logic [3:0]  target;
        logic [3:0]  previous;
    } ctl_t;

endpackage
`default_nettype wire

[rtl/bpss_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery pack switch sequencer step logic
// Decodes one transaction against the current sequencer state and produces
// the next state and the result of that step.
// ----------------------------------------------------------------------------
module bpss_core import bpss_pkg::*; #(
    parameter int NUM_PACKS = 3
) (
    input  wire in_t                    item,
    input  wire ctl_t                   ctl,
    input  wire logic [NUM_PACKS-1:0][2:0] shadow,
    input  wire logic [15:0]            timeout_ticks,
    output ctl_t                        ctl_next,
    output logic [NUM_PACKS-1:0][2:0]   shadow_next,
    output out_t                        result
);

    localparam int CNT_W = $clog2(NUM_PACKS + 1);

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_HOLD,
        ACT_ISSUE,
        ACT_TIMEOUT,
        ACT_ENTER_MAIN,
        ACT_ENTER_FIN,
        ACT_FAIL_DONE,
        ACT_DONE_OK,
        ACT_REJECT,
        ACT_BUSY,
        ACT_ALREADY,
        ACT_START,
        ACT_RELEASE,
        ACT_COMPLETE
    } act_t;

    logic [NUM_PACKS-1:0][2:0] st_now;
    logic [NUM_PACKS-1:0]      conn;

    // Packs beyond the input fields read as absent and disconnected.
    for (genvar g = 0; g < NUM_PACKS; g++) begin : g_pack
        if (g < FIELD_PACKS) begin : g_field
            assign st_now[g] = item.pack_states[3*g +: 3];
            assign conn[g]   = item.connected_mask[g];
        end else begin : g_absent
            assign st_now[g] = ST_ABSENT;
            assign conn[g]   = 1'b0;
        end
    end

    logic             tgt_valid;
    logic             prev_valid;
    logic             port_valid;
    logic [2:0]       rep_tgt;
    logic [2:0]       st_tgt;
    logic [2:0]       shadow_tgt;
    logic [2:0]       st_port;
    logic             conn_port;
    logic             pre_hit;
    logic [2:0]       pre_idx;
    logic             fin_hit;
    logic [2:0]       fin_idx;
    logic [CNT_W-1:0] fin_count;
    logic             req_hit;
    logic [2:0]       req_idx;
    logic             timed_out;
    logic             cmd_known;
    logic             req_mode_ok;
    logic             already;
    act_t             act;
    logic [2:0]       iss_pack;
    logic [3:0]       iss_cmd;

    assign tgt_valid  = ctl.target < 4'(NUM_PACKS);
    assign prev_valid = ctl.previous < 4'(NUM_PACKS);
    assign port_valid = {1'b0, item.port} < 4'(NUM_PACKS);
    assign rep_tgt    = tgt_valid ? ctl.target[2:0] : 3'd0;
    assign timed_out  = ctl.elapsed >= timeout_ticks;
    assign cmd_known  = (item.cmd == CMD_CHARGE) || (item.cmd == CMD_ONLY_DIS) ||
                        (item.cmd == CMD_DISCHARGE) || (item.cmd == CMD_STANDBY);
    assign req_mode_ok = (item.cmd == CMD_CHARGE) || (item.cmd == CMD_DISCHARGE);
    assign already    = ((st_port == ST_DIS) && (item.cmd == CMD_DISCHARGE)) ||
                        ((st_port == ST_CHG) && (item.cmd == CMD_CHARGE));

    // Per-pack selections and lowest-index priority scans.
    always_comb begin
        st_tgt     = ST_ABSENT;
        shadow_tgt = ST_ABSENT;
        st_port    = ST_ABSENT;
        conn_port  = 1'b0;
        pre_hit    = 1'b0;
        pre_idx    = 3'd0;
        fin_hit    = 1'b0;
        fin_idx    = 3'd0;
        fin_count  = '0;
        req_hit    = 1'b0;
        req_idx    = 3'd0;
        for (int i = NUM_PACKS - 1; i >= 0; i--) begin
            if (4'(i) == ctl.target) begin
                st_tgt     = st_now[i];
                shadow_tgt = shadow[i];
            end
            if (3'(i) == item.port) begin
                st_port   = st_now[i];
                conn_port = conn[i];
            end
            if ((4'(i) != ctl.target) && (shadow[i] != ST_ONLY_DIS) &&
                    ((st_now[i] == ST_DIS) || (st_now[i] == ST_CHG))) begin
                pre_hit = 1'b1;
                pre_idx = 3'(i);
            end
            if ((4'(i) != ctl.target) && (shadow[i] == ST_ONLY_DIS)) begin
                fin_hit = 1'b1;
                fin_idx = 3'(i);
            end
            if ((4'(i) != ctl.target) && (st_now[i] <= ST_STANDBY)) begin
                fin_count = fin_count + CNT_W'(1);
            end
            if ((3'(i) != item.port) &&
                    (((st_now[i] == ST_DIS) && (item.cmd == CMD_DISCHARGE)) ||
                     ((st_now[i] == ST_CHG) && (item.cmd == CMD_CHARGE)))) begin
                req_hit = 1'b1;
                req_idx = 3'(i);
            end
        end
    end

    // Action decode for the transaction.
    always_comb begin
        act      = ACT_NONE;
        iss_pack = 3'd0;
        iss_cmd  = 4'd0;
        case (item.func)
            FUNC_TICK: begin
                if (ctl.phase == PH_FAIL) begin
                    act = ACT_FAIL_DONE;
                end else if (ctl.phase != PH_IDLE) begin
                    act = ACT_HOLD;
                    if (timed_out) begin
                        act = ACT_TIMEOUT;
                    end else if (!ctl.in_flight) begin
                        case (ctl.phase)
                            PH_RECOV: begin
                                if (prev_valid) begin
                                    act      = ACT_ISSUE;
                                    iss_pack = ctl.previous[2:0];
                                    iss_cmd  = ctl.pending;
                                end
                            end
                            PH_PRE: begin
                                if (pre_hit && (ctl.pending == CMD_DISCHARGE)) begin
                                    act      = ACT_ISSUE;
                                    iss_pack = pre_idx;
                                    iss_cmd  = CMD_ONLY_DIS;
                                end else if (pre_hit && (ctl.pending == CMD_CHARGE)) begin
                                    act      = ACT_ISSUE;
                                    iss_pack = pre_idx;
                                    iss_cmd  = CMD_STANDBY;
                                end else begin
                                    act = ACT_ENTER_MAIN;
                                end
                            end
                            PH_MAIN, PH_MERGE: begin
                                if (tgt_valid && (shadow_tgt != ST_DIS) &&
                                        (st_tgt == ST_STANDBY)) begin
                                    act      = ACT_ISSUE;
                                    iss_pack = ctl.target[2:0];
                                    iss_cmd  = ctl.pending;
                                end else if (tgt_valid &&
                                        ((st_tgt == ST_DIS) || (st_tgt == ST_CHG))) begin
                                    act = (ctl.phase == PH_MERGE) ? ACT_DONE_OK : ACT_ENTER_FIN;
                                end
                            end
                            PH_FIN: begin
                                if (fin_hit) begin
                                    act      = ACT_ISSUE;
                                    iss_pack = fin_idx;
                                    iss_cmd  = CMD_STANDBY;
                                end else if (fin_count >= CNT_W'(NUM_PACKS - 1)) begin
                                    act = ACT_DONE_OK;
                                end
                            end
                            default: begin
                                act = ACT_HOLD;
                            end
                        endcase
                    end
                end
            end
            FUNC_SWITCH, FUNC_MERGE: begin
                if (!port_valid || !req_mode_ok || !conn_port) begin
                    act = ACT_REJECT;
                end else if (ctl.pending < CMD_NONE) begin
                    act = ACT_BUSY;
                end else if (already) begin
                    act = ACT_ALREADY;
                end else begin
                    act = ACT_START;
                end
            end
            FUNC_RELEASE: begin
                if (ctl.pending < CMD_NONE) begin
                    act = ACT_RELEASE;
                end
            end
            FUNC_DONE: begin
                if (cmd_known) begin
                    act = ACT_COMPLETE;
                end
            end
            default: begin
                act = ACT_NONE;
            end
        endcase
    end

    // Next state.
    always_comb begin
        ctl_next    = ctl;
        shadow_next = shadow;
        case (act)
            ACT_HOLD: begin
                if (ctl.elapsed != ELAPSED_MAX) begin
                    ctl_next.elapsed = ctl.elapsed + 16'd1;
                end
            end
            ACT_ISSUE: begin
                ctl_next.in_flight = 1'b1;
                if (ctl.elapsed != ELAPSED_MAX) begin
                    ctl_next.elapsed = ctl.elapsed + 16'd1;
                end
            end
            ACT_TIMEOUT: begin
                ctl_next.phase   = (ctl.phase == PH_FIN) ? PH_RECOV : PH_FAIL;
                ctl_next.elapsed = '0;
            end
            ACT_ENTER_MAIN: begin
                ctl_next.phase   = PH_MAIN;
                ctl_next.elapsed = '0;
            end
            ACT_ENTER_FIN: begin
                ctl_next.phase   = PH_FIN;
                ctl_next.elapsed = '0;
            end
            ACT_FAIL_DONE, ACT_DONE_OK, ACT_RELEASE: begin
                ctl_next.phase     = PH_IDLE;
                ctl_next.elapsed   = '0;
                ctl_next.pending   = CMD_NONE;
                ctl_next.in_flight = 1'b0;
                ctl_next.target    = PACK_NONE;
                ctl_next.previous  = PACK_NONE;
                shadow_next        = st_now;
            end
            ACT_START: begin
                ctl_next.phase     = (item.func == FUNC_SWITCH) ? PH_PRE : PH_MERGE;
                ctl_next.elapsed   = '0;
                ctl_next.pending   = item.cmd;
                ctl_next.in_flight = 1'b0;
                ctl_next.target    = {1'b0, item.port};
                ctl_next.previous  = req_hit ? {1'b0, req_idx} : PACK_NONE;
            end
            ACT_COMPLETE: begin
                ctl_next.in_flight = 1'b0;
                if (!item.cmd_failed) begin
                    // A recovery success goes idle but leaves the command pending.
                    if (ctl.phase == PH_RECOV) begin
                        ctl_next.phase   = PH_IDLE;
                        ctl_next.elapsed = '0;
                        shadow_next      = st_now;
                    end else begin
                        for (int i = 0; i < NUM_PACKS; i++) begin
                            if (3'(i) == item.port) begin
                                case (ctl.phase)
                                    PH_PRE: begin
                                        if (item.cmd == CMD_ONLY_DIS) begin
                                            shadow_next[i] = ST_ONLY_DIS;
                                        end
                                    end
                                    PH_MAIN, PH_MERGE: begin
                                        shadow_next[i] = ST_DIS;
                                    end
                                    PH_FIN: begin
                                        shadow_next[i] = ST_STANDBY;
                                    end
                                    default: begin
                                        shadow_next[i] = shadow[i];
                                    end
                                endcase
                            end
                        end
                    end
                end
            end
            default: begin
                ctl_next = ctl;
            end
        endcase
    end

    // Result of the step.
    always_comb begin
        result           = '0;
        result.phase_now = ctl_next.phase;
        case (act)
            ACT_ISSUE: begin
                result.issue_valid = 1'b1;
                result.issue_pack  = iss_pack;
                result.issue_cmd   = iss_cmd;
            end
            ACT_FAIL_DONE, ACT_RELEASE: begin
                result.report_valid = 1'b1;
                result.report_pack  = rep_tgt;
            end
            ACT_DONE_OK: begin
                result.report_valid = 1'b1;
                result.report_ok    = 1'b1;
                result.report_pack  = rep_tgt;
            end
            ACT_REJECT: begin
                result.request_status = STAT_REJECTED;
                result.report_valid   = 1'b1;
                result.report_pack    = item.port;
            end
            ACT_BUSY: begin
                result.request_status = STAT_BUSY;
                result.report_valid   = 1'b1;
                result.report_pack    = item.port;
            end
            ACT_ALREADY: begin
                result.request_status = STAT_ALREADY;
                result.report_valid   = 1'b1;
                result.report_ok      = 1'b1;
                result.report_pack    = item.port;
            end
            default: begin
                result.request_status = STAT_OK;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/battery_pack_switch_sequencer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// The sequencer takes one transaction per clock cycle and returns exactly one
// result transaction for each, registered in the cycle after it is accepted. All decoding,
// pack scans and state updates are done in a single combinational pass from
// the accepted transaction and the state registers into the result register,
// so the rate is one transaction per cycle as long as the result side takes
// its output; s_ready drops only while a result is held back by m_ready.
// ----------------------------------------------------------------------------
// Battery pack switch sequencer top level
// Make-before-break handover between battery packs: request checking, phase
// sequencing with timeouts, pack command issue and completion tracking.
// ----------------------------------------------------------------------------
module battery_pack_switch_sequencer_top import bpss_pkg::*; #(
    parameter int NUM_PACKS = 3
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_t             m_data
);

    ctl_t                      ctl_reg;
    ctl_t                      ctl_next;
    logic [NUM_PACKS-1:0][2:0] shadow_reg;
    logic [NUM_PACKS-1:0][2:0] shadow_next;
    logic [15:0]               timeout_reg;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    out_t                      m_data_reg;
    out_t                      result;
    logic                      accept;

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign m_valid_next = accept || (m_valid_reg && !m_ready);
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

    bpss_core #(
        .NUM_PACKS(NUM_PACKS)
    ) u_core (
        .item         (s_data),
        .ctl          (ctl_reg),
        .shadow       (shadow_reg),
        .timeout_ticks(timeout_reg),
        .ctl_next     (ctl_next),
        .shadow_next  (shadow_next),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.phase     <= PH_IDLE;
            ctl_reg.elapsed   <= '0;
            ctl_reg.pending   <= CMD_NONE;
            ctl_reg.in_flight <= 1'b0;
            ctl_reg.target    <= PACK_NONE;
            ctl_reg.previous  <= PACK_NONE;
            for (int i = 0; i < NUM_PACKS; i++) begin
                shadow_reg[i] <= ST_IDLE;
            end
            timeout_reg <= TIMEOUT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                ctl_reg    <= ctl_next;
                shadow_reg <= shadow_next;
            end
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    // The reported phase is the phase the sequencer moved into.
    a_phase_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_data.phase_now == 3'(ctl_reg.phase)))
        else $error("reported phase differs from sequencer phase");

    // An issued command always leaves a command in flight.
    a_issue_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (!m_data.issue_valid || ctl_reg.in_flight))
        else $error("command issued without in-flight mark");

    // With nothing pending the sequencer is idle and holds no target.
    a_none_pending_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_reg.pending == CMD_NONE) |->
            ((ctl_reg.phase == PH_IDLE) && (ctl_reg.target == PACK_NONE) &&
             !ctl_reg.in_flight))
        else $error("no command pending but sequencer not idle");

    // Any nonzero request status comes with a report.
    a_status_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.request_status == STAT_OK) || m_data.report_valid))
        else $error("request status without report");
`endif

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery pack switch sequencer testbench
// Drives request, tick, release and completion transactions into the
// sequencer. A pack environment answers the commands that the sequencer
// issues. Every result transaction is checked field by field against an
// in-bench model of the handover phases, under several timeout settings and
// idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module testbench import bpss_pkg::*;;

    localparam int NPACKS      = 3;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [2:0] FUNC_SPARE_TOP = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;

    // Sequencer state as the model sees it.
    phase_t      seq_phase;
    logic [15:0] seq_elapsed;
    logic [2:0]  seq_shadow [NPACKS];
    logic [3:0]  seq_pending;
    logic        seq_in_flight;
    logic [3:0]  seq_target;
    logic [3:0]  seq_previous;
    logic [15:0] seq_timeout;
    out_t        step_out;

    out_t expected_results [$];

    // Pack environment that answers issued commands.
    logic [8:0] env_states;
    logic [2:0] env_mask;
    logic       owed_valid;
    logic [2:0] owed_pack;
    logic [3:0] owed_cmd;
    int reply_pct;
    int fail_pct;
    int lose_pct;
    int noise_pct;

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_left;

    int errors;
    int cycle_count;
    int items_sent;
    int results_seen;
    int issue_count;
    int ok_reports;
    int fail_reports;

    battery_pack_switch_sequencer_top #(
        .NUM_PACKS(NPACKS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------
    function automatic logic [2:0] pack_state(logic [8:0] states, int idx);
        if (idx >= FIELD_PACKS) return ST_ABSENT;
        return states[3*idx +: 3];
    endfunction

    function automatic logic pack_connected(logic [2:0] mask, int idx);
        if (idx >= FIELD_PACKS) return 1'b0;
        return mask[idx];
    endfunction

    function automatic logic holds_mode(logic [2:0] st, logic [3:0] c);
        return (st == ST_DIS && c == CMD_DISCHARGE) || (st == ST_CHG && c == CMD_CHARGE);
    endfunction

    function automatic void enter_phase(phase_t p, logic [8:0] states);
        int i;
        seq_phase   = p;
        seq_elapsed = '0;
        if (p == PH_IDLE) begin
            for (i = 0; i < NPACKS; i++) seq_shadow[i] = pack_state(states, i);
        end
    endfunction

    function automatic void clear_request();
        seq_pending   = CMD_NONE;
        seq_target    = PACK_NONE;
        seq_previous  = PACK_NONE;
        seq_in_flight = 1'b0;
    endfunction

    function automatic void send_pack_cmd(logic [2:0] pack, logic [3:0] c);
        step_out.issue_valid = 1'b1;
        step_out.issue_pack  = pack;
        step_out.issue_cmd   = c;
        seq_in_flight        = 1'b1;
    endfunction

    function automatic void give_report(logic ok, logic [2:0] pack);
        step_out.report_valid = 1'b1;
        step_out.report_ok    = ok;
        step_out.report_pack  = pack;
    endfunction

    function automatic logic [2:0] target_or_zero();
        return (seq_target < NPACKS) ? seq_target[2:0] : 3'd0;
    endfunction

    function automatic void tick_phase(logic [8:0] states);
        phase_t     start_phase;
        logic       sent;
        int         check;
        int         i;
        int         tgt;
        logic [2:0] st;
        start_phase = seq_phase;
        sent        = 1'b0;
        check       = 0;
        tgt         = seq_target;
        if (seq_phase == PH_IDLE) return;
        if (seq_phase == PH_FAIL) begin
            give_report(1'b0, target_or_zero());
            clear_request();
            enter_phase(PH_IDLE, states);
            return;
        end
        if (seq_elapsed >= seq_timeout) begin
            enter_phase(seq_phase == PH_FIN ? PH_RECOV : PH_FAIL, states);
            return;
        end
        if (!seq_in_flight) begin
            case (seq_phase)
                PH_RECOV: begin
                    if (seq_previous < NPACKS) send_pack_cmd(seq_previous[2:0], seq_pending);
                end
                PH_PRE: begin
                    // Every other pack that still carries the load is moved aside first.
                    for (i = 0; i < NPACKS && !sent; i++) begin
                        st = pack_state(states, i);
                        if (i != tgt && seq_shadow[i] != ST_ONLY_DIS &&
                            (st == ST_DIS || st == ST_CHG)) begin
                            if (seq_pending == CMD_DISCHARGE) begin
                                send_pack_cmd(3'(i), CMD_ONLY_DIS);
                                sent = 1'b1;
                            end else if (seq_pending == CMD_CHARGE) begin
                                send_pack_cmd(3'(i), CMD_STANDBY);
                                sent = 1'b1;
                            end
                        end
                    end
                    if (!sent) enter_phase(PH_MAIN, states);
                end
                PH_MAIN, PH_MERGE: begin
                    if (tgt < NPACKS) begin
                        st = pack_state(states, tgt);
                        if (seq_shadow[tgt] != ST_DIS && st == ST_STANDBY) begin
                            send_pack_cmd(3'(tgt), seq_pending);
                        end else if (st == ST_DIS || st == ST_CHG) begin
                            if (seq_phase == PH_MERGE) begin
                                give_report(1'b1, 3'(tgt));
                                clear_request();
                                enter_phase(PH_IDLE, states);
                            end else begin
                                enter_phase(PH_FIN, states);
                            end
                        end
                    end
                end
                PH_FIN: begin
                    for (i = 0; i < NPACKS && !sent; i++) begin
                        if (i != tgt) begin
                            if (seq_shadow[i] == ST_ONLY_DIS) begin
                                send_pack_cmd(3'(i), CMD_STANDBY);
                                sent = 1'b1;
                            end else begin
                                st = pack_state(states, i);
                                if (st <= ST_IDLE || st == ST_STANDBY) check++;
                            end
                        end
                    end
                    if (!sent && check >= NPACKS - 1) begin
                        give_report(1'b1, target_or_zero());
                        clear_request();
                        enter_phase(PH_IDLE, states);
                    end
                end
                default: ;
            endcase
        end
        if (seq_phase == start_phase && seq_phase != PH_IDLE && seq_elapsed < ELAPSED_MAX)
            seq_elapsed++;
    endfunction

    function automatic void take_request(in_t t);
        int   port;
        int   i;
        logic found;
        port  = t.port;
        found = 1'b0;
        if (port >= NPACKS || (t.cmd != CMD_DISCHARGE && t.cmd != CMD_CHARGE) ||
            !pack_connected(t.connected_mask, port)) begin
            step_out.request_status = STAT_REJECTED;
            give_report(1'b0, t.port);
            return;
        end
        if (seq_pending < CMD_NONE) begin
            step_out.request_status = STAT_BUSY;
            give_report(1'b0, t.port);
            return;
        end
        if (holds_mode(pack_state(t.pack_states, port), t.cmd)) begin
            step_out.request_status = STAT_ALREADY;
            give_report(1'b1, t.port);
            return;
        end
        seq_pending   = t.cmd;
        seq_in_flight = 1'b0;
        seq_target    = 4'(port);
        seq_previous  = PACK_NONE;
        for (i = 0; i < NPACKS && !found; i++) begin
            if (i != port && holds_mode(pack_state(t.pack_states, i), t.cmd)) begin
                seq_previous = 4'(i);
                found        = 1'b1;
            end
        end
        enter_phase(t.func == FUNC_SWITCH ? PH_PRE : PH_MERGE, t.pack_states);
    endfunction

    function automatic void take_completion(in_t t);
        if (t.cmd < CMD_CHARGE || t.cmd > CMD_STANDBY) return;
        if (!t.cmd_failed) begin
            if (seq_phase == PH_RECOV) begin
                // The request stays pending after a recovery.
                enter_phase(PH_IDLE, t.pack_states);
            end else if (t.port < NPACKS) begin
                case (seq_phase)
                    PH_PRE: if (t.cmd == CMD_ONLY_DIS) seq_shadow[t.port] = ST_ONLY_DIS;
                    PH_MAIN, PH_MERGE: seq_shadow[t.port] = ST_DIS;
                    PH_FIN: seq_shadow[t.port] = ST_STANDBY;
                    default: ;
                endcase
            end
        end
        seq_in_flight = 1'b0;
    endfunction

    function automatic out_t sequencer_step(in_t t);
        step_out = '0;
        case (t.func)
            FUNC_TICK: tick_phase(t.pack_states);
            FUNC_SWITCH, FUNC_MERGE: take_request(t);
            FUNC_RELEASE: begin
                if (seq_pending < CMD_NONE) begin
                    give_report(1'b0, target_or_zero());
                    clear_request();
                    enter_phase(PH_IDLE, t.pack_states);
                end
            end
            FUNC_DONE: take_completion(t);
            default: ;
        endcase
        step_out.phase_now = seq_phase;
        return step_out;
    endfunction

    function automatic void sequencer_reset();
        int i;
        seq_timeout = TIMEOUT_RESET;
        seq_phase   = PH_IDLE;
        seq_elapsed = '0;
        for (i = 0; i < NPACKS; i++) seq_shadow[i] = ST_IDLE;
        clear_request();
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers and result checking
    // ------------------------------------------------------------------------
    function automatic int sender_gap();
        int g;
        g = 0;
        while ($urandom_range(99) < tx_idle_pct && g < 60) g++;
        return g;
    endfunction

    task automatic send_item(input in_t item);
        int   gap;
        out_t want;
        gap = sender_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = sequencer_step(item);
        expected_results.push_back(want);
        items_sent++;
        if (want.issue_valid) begin
            issue_count++;
            owed_valid = ($urandom_range(99) >= lose_pct);
            owed_pack  = want.issue_pack;
            owed_cmd   = want.issue_cmd;
        end
        if (want.report_valid) begin
            if (want.report_ok) ok_reports++;
            else fail_reports++;
        end
    endtask

    task automatic send_event(input logic [2:0] func, input logic [2:0] port,
                              input logic [3:0] cmd, input logic failed);
        in_t item;
        item.func           = func;
        item.port           = port;
        item.cmd            = cmd;
        item.cmd_failed     = failed;
        item.pack_states    = env_states;
        item.connected_mask = env_mask;
        send_item(item);
    endtask

    task automatic send_tick();
        send_event(FUNC_TICK, 3'($urandom), 4'($urandom), 1'($urandom));
    endtask

    function automatic in_t random_item();
        in_t it;
        it.func           = 3'($urandom_range(7));
        it.port           = 3'($urandom_range(7));
        it.cmd            = 4'($urandom_range(15));
        it.cmd_failed     = 1'($urandom_range(1));
        it.pack_states    = 9'($urandom_range(511));
        it.connected_mask = 3'($urandom_range(7));
        return it;
    endfunction

    // Reports the owed command back and, on success, moves the pack to the state it asked for.
    task automatic reply_owed(input logic failed);
        logic [2:0] reached;
        if (owed_valid) begin
            send_event(FUNC_DONE, owed_pack, owed_cmd, failed);
            owed_valid = 1'b0;
            case (owed_cmd)
                CMD_CHARGE:    reached = ST_CHG;
                CMD_ONLY_DIS:  reached = ST_ONLY_DIS;
                CMD_DISCHARGE: reached = ST_DIS;
                default:       reached = ST_STANDBY;
            endcase
            if (!failed) env_states[3*owed_pack +: 3] = reached;
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_timeout(input logic [15:0] ticks);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        seq_timeout = ticks;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $error("result transaction with nothing expected: %p", m_data);
            end else begin
                want = expected_results.pop_front();
                check_field("issue_valid", want.issue_valid, m_data.issue_valid);
                check_field("issue_pack", want.issue_pack, m_data.issue_pack);
                check_field("issue_cmd", want.issue_cmd, m_data.issue_cmd);
                check_field("report_valid", want.report_valid, m_data.report_valid);
                check_field("report_ok", want.report_ok, m_data.report_ok);
                check_field("report_pack", want.report_pack, m_data.report_pack);
                check_field("request_status", want.request_status, m_data.request_status);
                check_field("phase_now", want.phase_now, m_data.phase_now);
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic logic [2:0] random_pack_code();
        int r;
        r = $urandom_range(99);
        if (r < 6) return 3'($urandom_range(7, 6));
        if (r < 12) return ST_ABSENT;
        return 3'($urandom_range(ST_ONLY_DIS, ST_IDLE));
    endfunction

    function automatic void pick_environment(int tgt, logic [3:0] mode);
        int i;
        int other;
        for (i = 0; i < FIELD_PACKS; i++) begin
            env_states[3*i +: 3] = random_pack_code();
            env_mask[i]          = ($urandom_range(99) < 90);
        end
        if ($urandom_range(99) < 60) env_states[3*tgt +: 3] = ST_STANDBY;
        if ($urandom_range(99) < 60) begin
            other = (tgt + $urandom_range(NPACKS - 1, 1)) % NPACKS;
            env_states[3*other +: 3] = (mode == CMD_DISCHARGE) ? ST_DIS : ST_CHG;
        end
    endfunction

    task automatic run_handover(input logic [2:0] func, input logic [2:0] port,
                                input logic [3:0] mode, input int max_steps);
        int n;
        n          = 0;
        owed_valid = 1'b0;
        send_event(func, port, mode, 1'b0);
        while (n < max_steps && seq_phase != PH_IDLE) begin
            if (owed_valid && $urandom_range(99) < reply_pct)
                reply_owed($urandom_range(99) < fail_pct);
            else if ($urandom_range(99) < noise_pct)
                send_item(random_item());
            else
                send_tick();
            n++;
        end
        if (seq_pending != CMD_NONE && $urandom_range(99) < 70)
            send_event(FUNC_RELEASE, 3'($urandom), 4'($urandom), 1'b0);
    endtask

    task automatic set_clean_packs();
        reply_pct = 100;
        fail_pct  = 0;
        lose_pct  = 0;
        noise_pct = 0;
    endtask

    task automatic test_idle_events();
        int f;
        env_states = 9'($urandom_range(511));
        env_mask   = '1;
        send_tick();
        for (f = int'(FUNC_DONE) + 1; f <= int'(FUNC_SPARE_TOP); f++)
            send_event(3'(f), 3'($urandom), 4'($urandom), 1'($urandom));
        send_event(FUNC_RELEASE, 3'd0, CMD_NONE, 1'b0);
        send_event(FUNC_DONE, 3'd0, '0, 1'b0);
        send_event(FUNC_DONE, 3'd1, CMD_NONE, 1'b0);
        send_event(FUNC_DONE, 3'd2, '1, 1'b1);
        send_event(FUNC_DONE, 3'd7, CMD_CHARGE, 1'b0);
    endtask

    task automatic test_request_checks();
        env_states = {ST_STANDBY, ST_CHG, ST_DIS};
        env_mask   = 3'b011;
        send_event(FUNC_SWITCH, 3'd7, CMD_DISCHARGE, 1'b0);
        send_event(FUNC_SWITCH, 3'd3, CMD_CHARGE, 1'b0);
        send_event(FUNC_MERGE, 3'd2, CMD_DISCHARGE, 1'b0);
        send_event(FUNC_SWITCH, 3'd0, CMD_ONLY_DIS, 1'b0);
        send_event(FUNC_SWITCH, 3'd0, '0, 1'b0);
        send_event(FUNC_MERGE, 3'd1, '1, 1'b0);
        send_event(FUNC_SWITCH, 3'd0, CMD_DISCHARGE, 1'b0);
        send_event(FUNC_MERGE, 3'd1, CMD_CHARGE, 1'b0);
        env_mask = '1;
        send_event(FUNC_MERGE, 3'd2, CMD_DISCHARGE, 1'b0);
        send_event(FUNC_SWITCH, 3'd1, CMD_DISCHARGE, 1'b0);
        send_event(FUNC_RELEASE, 3'd0, CMD_NONE, 1'b0);
    endtask

    task automatic test_switch_handover();
        set_clean_packs();
        env_states = {ST_IDLE, ST_STANDBY, ST_DIS};
        env_mask   = '1;
        run_handover(FUNC_SWITCH, 3'd1, CMD_DISCHARGE, 30);
    endtask

    task automatic test_merge();
        set_clean_packs();
        env_states = {ST_STANDBY, ST_IDLE, ST_DIS};
        env_mask   = '1;
        run_handover(FUNC_MERGE, 3'd2, CMD_DISCHARGE, 20);
    endtask

    task automatic test_phase_timeout();
        set_clean_packs();
        write_timeout(16'd2);
        env_states = {ST_IDLE, ST_IDLE, ST_IDLE};
        env_mask   = '1;
        run_handover(FUNC_SWITCH, 3'd1, CMD_CHARGE, 12);
    endtask

    // Finish phase loses its standby completion, times out into recovery, and a
    // late success there returns to idle with the request still pending.
    task automatic test_recovery();
        set_clean_packs();
        write_timeout(16'd3);
        env_states = {ST_IDLE, ST_STANDBY, ST_DIS};
        env_mask   = '1;
        owed_valid = 1'b0;
        send_event(FUNC_SWITCH, 3'd1, CMD_DISCHARGE, 1'b0);
        while (seq_phase != PH_FIN) begin
            if (owed_valid) reply_owed(1'b0);
            else send_tick();
        end
        send_tick();
        owed_valid = 1'b0;
        while (seq_phase == PH_FIN) send_tick();
        send_event(FUNC_DONE, 3'd0, CMD_STANDBY, 1'b1);
        send_tick();
        reply_owed(1'b0);
        send_event(FUNC_MERGE, 3'd2, CMD_DISCHARGE, 1'b0);
        send_event(FUNC_RELEASE, 3'd0, CMD_NONE, 1'b0);
    endtask

    task automatic test_backpressure();
        int n;
        hold_left = 300;
        for (n = 0; n < 40; n++) begin
            if (n % 4 == 0) send_item(random_item());
            else send_tick();
        end
        drain_results();
    endtask

    task automatic random_handover();
        int         tgt;
        logic [3:0] mode;
        logic [2:0] func;
        tgt  = $urandom_range(NPACKS - 1);
        mode = $urandom_range(1) ? CMD_DISCHARGE : CMD_CHARGE;
        func = ($urandom_range(99) < 70) ? FUNC_SWITCH : FUNC_MERGE;
        if ($urandom_range(99) < 25) begin
            set_clean_packs();
        end else begin
            reply_pct = 80;
            fail_pct  = 10;
            lose_pct  = 8;
            noise_pct = 6;
        end
        pick_environment(tgt, mode);
        run_handover(func, 3'(tgt), mode, $urandom_range(60, 10));
    endtask

    task automatic test_random_traffic();
        int          chunk;
        int          stop_at;
        logic [15:0] ticks;
        for (chunk = 0; chunk < 8; chunk++) begin
            case (chunk)
                0: ticks = 16'd3;
                1: ticks = 16'd1;
                2: ticks = 16'hFFFF;
                3: ticks = 16'd8;
                4: ticks = 16'd2;
                5: ticks = 16'($urandom_range(40, 1));
                6: ticks = 16'd20;
                default: ticks = TIMEOUT_RESET;
            endcase
            write_timeout(ticks);
            case (chunk % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
            endcase
            stop_at = items_sent + 75;
            while (items_sent < stop_at) begin
                if ($urandom_range(99) < 85) random_handover();
                else send_item(random_item());
            end
        end
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        hold_left    = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        errors       = 0;
        cycle_count  = 0;
        items_sent   = 0;
        results_seen = 0;
        issue_count  = 0;
        ok_reports   = 0;
        fail_reports = 0;
        owed_valid   = 1'b0;
        owed_pack    = '0;
        owed_cmd     = '0;
        env_states   = '0;
        env_mask     = '0;
        set_clean_packs();
        sequencer_reset();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_events();
        test_request_checks();
        test_switch_handover();
        test_merge();
        test_phase_timeout();
        test_recovery();
        test_backpressure();
        test_random_traffic();
        drain_results();

        $display("Run covered %0d transactions and %0d checked results under eight timeout",
                 items_sent, results_seen);
        $display("settings: %0d pack commands issued, %0d success and %0d failure reports.",
                 issue_count, ok_reports, fail_reports);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
